[src/cpa_pkg.sv]
// Shared types and constants for the clamped PID attitude axis block.
package cpa_pkg;

  localparam int DivNW  = 32;  // dividend / quotient width
  localparam int DivDW  = 17;  // divisor width
  localparam int MulAW  = 36;  // signed multiplier operand a
  localparam int MulBW  = 18;  // signed multiplier operand b
  localparam int MulPW  = MulAW + MulBW;
  localparam int CfgIdxW = 4;
  localparam int CfgW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_P_LIMITS     = 4'd0,
    CFG_I_LIMITS     = 4'd1,
    CFG_D_LIMITS     = 4'd2,
    CFG_KP_GAINS     = 4'd3,
    CFG_KI_GAINS     = 4'd4,
    CFG_KD_GAINS     = 4'd5,
    CFG_REVERSE_BITS = 4'd6,
    CFG_MANUAL_BLEND = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quotient;
    logic             rem_nz;
  } div_rsp_t;

endpackage

[src/cpa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module cpa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpa_pkg::div_req_t req_i,
  output cpa_pkg::div_rsp_t rsp_o
);
  import cpa_pkg::*;

  localparam int CntW = $clog2(DivNW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [DivDW:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, quo_q[DivNW-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? DivDW'(trial - {1'b0, den_q}) : DivDW'(trial);
      quo_d = {quo_q[DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_nz   = rem_q != '0;

endmodule

[src/cpa_mul.sv]
// Shared signed multiplier with registered product.
module cpa_mul (
  input  logic                               clk_i,
  input  logic signed [cpa_pkg::MulAW-1:0]   a_i,
  input  logic signed [cpa_pkg::MulBW-1:0]   b_i,
  output logic signed [cpa_pkg::MulPW-1:0]   p_o
);
  import cpa_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

[src/clamped_pid_attitude_axis_top.sv]
// Top level of the clamped PID attitude axis controller.
//
// One input transaction is one control tick for one axis. The sequencer
// wraps the angle error, updates the per-axis integrator and previous P
// term, then runs every division through one shared 32-step divider and
// every product through one shared registered multiplier.
// Input channel: in_valid_i / in_stall_o; in_stall_o is high while a tick
// is being worked on. Output channel: out_valid_o / out_stall_i with an
// output register, so a finished result may wait while the next tick runs.
// Sequence: the error wrap (with an extra step when the raw error lies past
// +-pi), five divider passes (knob, three normalizations, manual share)
// and the remaining sequencer states up to the output register. The block
// returns to idle before it accepts again, so it takes no new tick while
// one is still being worked on.
// If the output register is still held by a stalled receiver when a new
// result is ready, the sequencer waits until it is taken.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), index and data;
// writes are meant for idle time only. Unknown indexes are dropped.
// Reset clears config, integrators, previous P terms and all handshakes.
module clamped_pid_attitude_axis_top #(
  parameter int AXES            = 3,
  parameter int PULSE_RANGE     = 500,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cpa_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    axis_i,
  input  logic signed [15:0]            measured_angle_i,
  input  logic signed [15:0]            target_angle_i,
  input  logic [11:0]                   stick_pulse_i,
  input  logic [11:0]                   stick_center_i,
  input  logic [11:0]                   gain_knob_pulse_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [10:0]                   servo_pulse_o,
  output logic signed [15:0]            drive_o,
  output logic signed [15:0]            p_term_o,
  output logic signed [15:0]            i_term_o,
  output logic signed [15:0]            d_term_o
);
  import cpa_pkg::*;

  localparam longint PiQ   = (64'd3373259426 + (64'd1 << (29 - ANGLE_FRAC_BITS)))
                             >> (30 - ANGLE_FRAC_BITS);
  localparam longint TwoPi = 2 * PiQ;
  localparam int     EW    = $clog2(TwoPi + 65536) + 2;  // wrap register width
  localparam int     CW    = EW + 2;                     // clamp arithmetic width
  localparam int     AW    = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_PRE, S_KNOB, S_NP, S_NI, S_ND,
    S_SUM1, S_SUM2, S_SUM3, S_SUM4, S_KMUL, S_PID, S_AUTO,
    S_MANM, S_MAND, S_PMUL, S_PULSE, S_OUT
  } state_e;

  // ---------------------------------------------------------------- config
  logic [CfgW-1:0] p_lim_q, i_lim_q, d_lim_q, kp_q, ki_q, kd_q;
  logic [5:0]      rev_q;
  logic [15:0]     blend_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_lim_q <= '0;
      i_lim_q <= '0;
      d_lim_q <= '0;
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      rev_q   <= '0;
      blend_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_P_LIMITS:     p_lim_q <= cfg_data_i;
        CFG_I_LIMITS:     i_lim_q <= cfg_data_i;
        CFG_D_LIMITS:     d_lim_q <= cfg_data_i;
        CFG_KP_GAINS:     kp_q    <= cfg_data_i;
        CFG_KI_GAINS:     ki_q    <= cfg_data_i;
        CFG_KD_GAINS:     kd_q    <= cfg_data_i;
        CFG_REVERSE_BITS: rev_q   <= cfg_data_i[5:0];
        CFG_MANUAL_BLEND: blend_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Per-axis slot of a packed 48-bit register; axes past the third read 0.
  function automatic logic [15:0] slot_f(logic [CfgW-1:0] r, int unsigned a);
    logic [15:0] s;
    if (a == 0)      s = r[15:0];
    else if (a == 1) s = r[31:16];
    else if (a == 2) s = r[47:32];
    else             s = '0;
    return s;
  endfunction

  function automatic logic signed [CW-1:0] clampv(logic signed [CW-1:0] v,
                                                  logic signed [CW-1:0] lo,
                                                  logic signed [CW-1:0] hi);
    logic signed [CW-1:0] r;
    if (v < lo)      r = lo;
    else if (v > hi) r = hi;
    else             r = v;
    return r;
  endfunction

  function automatic logic [16:0] mag_f(logic signed [15:0] t);
    logic signed [16:0] t17;
    t17 = 17'(t);
    return (t17 < 0) ? 17'(-t17) : 17'(t17);
  endfunction

  // term * 2^14 / lim, truncated and clamped to +-2^14
  function automatic logic signed [15:0] norm_f(logic signed [15:0] t, logic [15:0] lim,
                                                logic [DivNW-1:0] q);
    logic [16:0]        m;
    logic signed [15:0] r;
    m = mag_f(t);
    if (t == 0)                r = '0;
    else if (m >= {1'b0, lim}) r = t[15] ? -16'sd16384 : 16'sd16384;
    else                       r = t[15] ? -signed'({2'b0, q[13:0]})
                                         : signed'({2'b0, q[13:0]});
    return r;
  endfunction

  // ---------------------------------------------------------------- datapath
  state_e state_q;

  logic [AW-1:0]          ax_q;
  logic [11:0]            stick_q, center_q, knobp_q;
  logic signed [EW-1:0]   wrap_q;
  logic signed [15:0]     integ_q [AXES];
  logic signed [15:0]     prev_q  [AXES];
  logic signed [15:0]     p_q, acc_q, d_q;
  logic signed [12:0]     rc_q;
  logic [16:0]            knob_q;
  logic signed [15:0]     np_q, ni_q, nd_q;
  logic signed [MulAW-1:0] sum_q;
  logic signed [21:0]     auto_q, total_q;
  logic                   man_neg_q;
  logic [10:0]            pulse_q;
  logic signed [15:0]     drive_q;

  logic                   out_valid_q;
  logic [10:0]            o_pulse_q;
  logic signed [15:0]     o_drive_q, o_p_q, o_i_q, o_d_q;

  int unsigned            axn;
  logic [15:0]            plim, ilim, dlim, kp, ki, kd;
  logic                   srev, rrev;

  always_comb begin
    axn  = 32'(ax_q);
    plim = slot_f(p_lim_q, axn);
    ilim = slot_f(i_lim_q, axn);
    dlim = slot_f(d_lim_q, axn);
    kp   = slot_f(kp_q, axn);
    ki   = slot_f(ki_q, axn);
    kd   = slot_f(kd_q, axn);
    srev = (axn < 3) && rev_q[axn[1:0]];
    rrev = (axn < 3) && rev_q[3 + axn[1:0]];
  end

  // Error, clamps and integrator update, used in S_PRE.
  logic signed [EW-1:0] err_raw, err;
  logic signed [CW-1:0] acc1, acc2, pc, d1, dc;
  logic signed [CW-1:0] ilim_s, plim_s;
  logic signed [15:0]   p16, acc16, d16;
  logic signed [12:0]   rc_v;
  logic signed [12:0]   knob_x;
  logic [DivNW-1:0]     knob_div;

  always_comb begin
    err_raw = wrap_q - EW'(PiQ);
    err     = srev ? -err_raw : err_raw;
    ilim_s  = signed'(CW'(ilim));
    plim_s  = signed'(CW'(plim));
    acc1    = CW'(integ_q[ax_q]) + CW'(err);
    acc2    = clampv(clampv(acc1, -ilim_s, ilim_s), CW'(-32768), CW'(32767));
    pc      = clampv(clampv(CW'(err), -plim_s, plim_s), CW'(-32768), CW'(32767));
    p16     = pc[15:0];
    d1      = CW'(p16) - CW'(prev_q[ax_q]);
    dc      = clampv(d1, CW'(-32768), CW'(32767));
    d16     = dc[15:0];
    acc16   = acc2[15:0];
    if ((acc16 < 0 && p16 > 0) || (acc16 > 0 && p16 < 0)) acc16 = '0;
    rc_v    = signed'({1'b0, stick_q}) - signed'({1'b0, center_q});
    if (rrev) rc_v = -rc_v;
    knob_x  = signed'({1'b0, knobp_q}) - 13'sd1000;
    if (knob_x >= 0 && knob_x < 13'sd1040) knob_div = DivNW'(knob_x) << 14;
    else                                     knob_div = '0;
  end

  // ---------------------------------------------------------------- shared units
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  cpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cpa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  logic [16:0]             mcomp;
  logic signed [21:0]      pid_v;
  logic [DivNW-1:0]        man_mag;
  logic signed [21:0]      manual_v;
  logic signed [MulPW-1:0] psum, pfl;

  always_comb begin
    mcomp    = 17'h10000 - {1'b0, blend_q};
    pid_v    = 22'(prod >>> 28);
    man_mag  = prod[MulPW-1] ? DivNW'(-prod) : DivNW'(prod);
    manual_v = man_neg_q ? -(22'(div_rsp.quotient) + 22'(div_rsp.rem_nz))
                         : 22'(div_rsp.quotient);
    psum     = prod + (MulPW'(center_q) <<< 14);
    pfl      = psum >>> 14;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      S_PRE: begin
        div_req.start    = 1'b1;
        div_req.dividend = knob_div;
        div_req.divisor  = 17'd520;
      end
      S_KNOB: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DivNW'(mag_f(p_q)) << 14;
        div_req.divisor  = {1'b0, plim};
      end
      S_NP: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DivNW'(mag_f(acc_q)) << 14;
        div_req.divisor  = {1'b0, ilim};
      end
      S_NI: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DivNW'(mag_f(d_q)) << 14;
        div_req.divisor  = {1'b0, dlim};
      end
      S_MANM: begin
        div_req.start    = 1'b1;
        div_req.dividend = man_mag;
        div_req.divisor  = DivDW'(4 * PULSE_RANGE);
      end
      default: ;
    endcase

    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SUM1:  begin mul_a = MulAW'(kp);       mul_b = MulBW'(np_q); end
      S_SUM2:  begin mul_a = MulAW'(ki);       mul_b = MulBW'(ni_q); end
      S_SUM3:  begin mul_a = MulAW'(kd);       mul_b = MulBW'(nd_q); end
      S_KMUL:  begin mul_a = sum_q;            mul_b = signed'({1'b0, knob_q}); end
      S_PID:   begin mul_a = MulAW'(pid_v);    mul_b = signed'({1'b0, mcomp}); end
      S_AUTO:  begin mul_a = MulAW'(rc_q);     mul_b = signed'({2'b0, blend_q}); end
      S_PMUL:  begin mul_a = MulAW'(total_q);  mul_b = MulBW'(PULSE_RANGE); end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
    end else begin
      if (out_load)                       out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_WRAP;
        S_WRAP: if (wrap_q >= 0 && wrap_q < EW'(TwoPi)) state_q <= S_PRE;
        S_PRE: begin
          integ_q[ax_q] <= acc16;
          prev_q[ax_q]  <= p16;
          state_q       <= S_KNOB;
        end
        S_KNOB: if (div_rsp.done) state_q <= S_NP;
        S_NP:   if (div_rsp.done) state_q <= S_NI;
        S_NI:   if (div_rsp.done) state_q <= S_ND;
        S_ND:   if (div_rsp.done) state_q <= S_SUM1;
        S_SUM1: state_q <= S_SUM2;
        S_SUM2: state_q <= S_SUM3;
        S_SUM3: state_q <= S_SUM4;
        S_SUM4: state_q <= S_KMUL;
        S_KMUL: state_q <= S_PID;
        S_PID:  state_q <= S_AUTO;
        S_AUTO: state_q <= S_MANM;
        S_MANM: state_q <= S_MAND;
        S_MAND: if (div_rsp.done) state_q <= S_PMUL;
        S_PMUL: state_q <= S_PULSE;
        S_PULSE: state_q <= S_OUT;
        S_OUT:  if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        ax_q     <= (32'(axis_i) >= AXES) ? AW'(AXES - 1) : AW'(axis_i);
        stick_q  <= stick_pulse_i;
        center_q <= stick_center_i;
        knobp_q  <= gain_knob_pulse_i;
        wrap_q   <= EW'(measured_angle_i) - EW'(target_angle_i) + EW'(PiQ);
      end
      S_WRAP: begin
        if (wrap_q < 0)                wrap_q <= wrap_q + EW'(TwoPi);
        else if (wrap_q >= EW'(TwoPi)) wrap_q <= wrap_q - EW'(TwoPi);
      end
      S_PRE: begin
        p_q   <= p16;
        acc_q <= acc16;
        d_q   <= d16;
        rc_q  <= rc_v;
      end
      S_KNOB: if (div_rsp.done) begin
        if (knob_x < 0)              knob_q <= '0;
        else if (knob_x >= 13'sd1040) knob_q <= 17'h08000;
        else                          knob_q <= div_rsp.quotient[16:0];
      end
      S_NP: if (div_rsp.done) np_q <= norm_f(p_q, plim, div_rsp.quotient);
      S_NI: if (div_rsp.done) ni_q <= norm_f(acc_q, ilim, div_rsp.quotient);
      S_ND: if (div_rsp.done) nd_q <= norm_f(d_q, dlim, div_rsp.quotient);
      S_SUM2: sum_q <= prod[MulAW-1:0];
      S_SUM3: sum_q <= sum_q + prod[MulAW-1:0];
      S_SUM4: sum_q <= sum_q + prod[MulAW-1:0];
      S_AUTO: auto_q <= 22'(prod >>> 16);
      S_MANM: man_neg_q <= prod[MulPW-1];
      S_MAND: if (div_rsp.done) total_q <= auto_q + manual_v;
      S_PULSE: begin
        if (pfl < 1000)      pulse_q <= 11'd1000;
        else if (pfl > 2000) pulse_q <= 11'd2000;
        else                 pulse_q <= pfl[10:0];
        if (total_q < -22'sd32768)     drive_q <= -16'sd32768;
        else if (total_q > 22'sd32767) drive_q <= 16'sd32767;
        else                           drive_q <= total_q[15:0];
      end
      default: ;
    endcase
    if (out_load) begin
      o_pulse_q <= pulse_q;
      o_drive_q <= drive_q;
      o_p_q     <= p_q;
      o_i_q     <= acc_q;
      o_d_q     <= d_q;
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign servo_pulse_o = o_pulse_q;
  assign drive_o       = o_drive_q;
  assign p_term_o      = o_p_q;
  assign i_term_o      = o_i_q;
  assign d_term_o      = o_d_q;

`ifndef SYNTH
  // Divider results only arrive while the sequencer waits on them.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_KNOB || state_q == S_NP || state_q == S_NI ||
                      state_q == S_ND || state_q == S_MAND))
    else $error("divider result outside a wait state");

  // An accepted transaction makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a transaction");

  // A held result is never overwritten by the sequencer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(drive_o) &&
                                      $stable(servo_pulse_o)))
    else $error("held result changed");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the clamped PID attitude axis block with a cycle-free predictor.
`timescale 1ns / 100ps

module testbench;
  import cpa_pkg::*;

  localparam int NumAxes      = 3;
  localparam int PulseSpan    = 500;
  localparam int FracBits     = 13;
  localparam int NumRegs      = 8;
  localparam int RandTicks    = 400;
  localparam int Phases       = 4;
  localparam int IdleLimit    = 5000;
  localparam int DrainCycles  = 400;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd9;
  localparam longint PiQ =
      (64'sd3373259426 + (64'sd1 << (29 - FracBits))) >>> (30 - FracBits);

  // Expected result of one tick.
  typedef struct {
    logic [10:0]        servo;
    logic signed [15:0] drive;
    logic signed [15:0] p;
    logic signed [15:0] i;
    logic signed [15:0] d;
  } tick_result_t;

  // Predicts each tick from the mirrored registers and per-axis state,
  // then matches the block's results in order.
  class pid_scoreboard;
    logic [CfgW-1:0]    regs [NumRegs];
    longint             integ [NumAxes];
    longint             prev_p [NumAxes];
    tick_result_t       expected_q [$];
    int                 errors;

    function new();
      foreach (regs[k]) regs[k] = '0;
      foreach (integ[k]) begin
        integ[k]  = 0;
        prev_p[k] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_REVERSE_BITS: regs[idx] = data & 48'h3F;
        CFG_MANUAL_BLEND: regs[idx] = data & 48'hFFFF;
        CFG_P_LIMITS, CFG_I_LIMITS, CFG_D_LIMITS,
        CFG_KP_GAINS, CFG_KI_GAINS, CFG_KD_GAINS: regs[idx] = data;
        default: ;  // unknown index dropped
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint field(cfg_idx_e r, int a);
      return longint'(regs[r][16*a +: 16]);
    endfunction

    function longint norm(longint term, longint lim);
      if (lim == 0) return term > 0 ? 16384 : (term < 0 ? -16384 : 0);
      return clip((term * 16384) / lim, -16384, 16384);
    endfunction

    function void note_tick(logic [1:0] axis, logic signed [15:0] meas,
                            logic signed [15:0] targ, logic [11:0] stick,
                            logic [11:0] center, logic [11:0] knob_pulse);
      int a;
      longint err, r, plim, ilim, dlim, acc, p, d, knob, pid, autov, manual;
      longint total, rc, m, pulse;
      tick_result_t res;
      a = axis >= NumAxes ? NumAxes - 1 : axis;
      plim = field(CFG_P_LIMITS, a);
      ilim = field(CFG_I_LIMITS, a);
      dlim = field(CFG_D_LIMITS, a);
      m    = longint'(regs[CFG_MANUAL_BLEND][15:0]);
      // wrap error into [-pi, pi)
      r = (longint'(meas) - longint'(targ) + PiQ) % (2 * PiQ);
      if (r < 0) r += 2 * PiQ;
      err = r - PiQ;
      if (regs[CFG_REVERSE_BITS][a]) err = -err;
      acc = clip(clip(integ[a] + err, -ilim, ilim), -32768, 32767);
      p = clip(clip(err, -plim, plim), -32768, 32767);
      d = clip(p - prev_p[a], -32768, 32767);
      prev_p[a] = p;
      // integrator dumped when it fights the proportional term
      if ((acc < 0 && p > 0) || (acc > 0 && p < 0)) acc = 0;
      integ[a] = acc;
      knob = clip(((longint'(knob_pulse) - 1000) * 16384) / 520, 0, 32768);
      pid = norm(p, plim) * field(CFG_KP_GAINS, a) * knob
          + norm(acc, ilim) * field(CFG_KI_GAINS, a) * knob
          + norm(d, dlim) * field(CFG_KD_GAINS, a) * knob;
      pid = fdiv(pid, 64'sd268435456);
      autov = fdiv(pid * (65536 - m), 65536);
      rc = longint'(stick) - longint'(center);
      if (regs[CFG_REVERSE_BITS][3 + a]) rc = -rc;
      manual = fdiv(rc * m, 4 * PulseSpan);
      total = autov + manual;
      pulse = clip(fdiv(longint'(center) * 16384 + total * PulseSpan, 16384), 1000, 2000);
      res.servo = pulse[10:0];
      res.drive = 16'(clip(total, -32768, 32767));
      res.p     = 16'(p);
      res.i     = 16'(acc);
      res.d     = 16'(d);
      expected_q.push_back(res);
    endfunction

    function void check(tick_result_t got);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no tick pending");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.servo !== exp_r.servo) begin
        $error("servo_pulse: expected %0d, got %0d", exp_r.servo, got.servo);
        errors++;
      end
      if (got.drive !== exp_r.drive) begin
        $error("drive: expected %0d, got %0d", exp_r.drive, got.drive);
        errors++;
      end
      if (got.p !== exp_r.p) begin
        $error("p_term: expected %0d, got %0d", exp_r.p, got.p);
        errors++;
      end
      if (got.i !== exp_r.i) begin
        $error("i_term: expected %0d, got %0d", exp_r.i, got.i);
        errors++;
      end
      if (got.d !== exp_r.d) begin
        $error("d_term: expected %0d, got %0d", exp_r.d, got.d);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          axis_i;
  logic signed [15:0]  measured_angle_i;
  logic signed [15:0]  target_angle_i;
  logic [11:0]         stick_pulse_i;
  logic [11:0]         stick_center_i;
  logic [11:0]         gain_knob_pulse_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [10:0]         servo_pulse_o;
  logic signed [15:0]  drive_o;
  logic signed [15:0]  p_term_o;
  logic signed [15:0]  i_term_o;
  logic signed [15:0]  d_term_o;

  pid_scoreboard sb = new();
  bit  quiet;       // no idling on either side
  int  idle_cycles;

  clamped_pid_attitude_axis_top #(
    .AXES(NumAxes), .PULSE_RANGE(PulseSpan), .ANGLE_FRAC_BITS(FracBits)
  ) DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitors: inputs and results are taken at the rising edge, before
  // the block's own updates land.
  always @(posedge clk_i) begin
    tick_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_tick(axis_i, measured_angle_i, target_angle_i,
                     stick_pulse_i, stick_center_i, gain_knob_pulse_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.servo = servo_pulse_o;
        got.drive = drive_o;
        got.p     = p_term_o;
        got.i     = i_term_o;
        got.d     = d_term_o;
        sb.check(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: a silence of IdleLimit cycles, many ticks long, fails the run.
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stall: random bursts, off once the run goes quiet.
  initial begin
    int len;
    bit level;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      len   = $urandom_range(1, 10);
      level = quiet ? 1'b0 : $urandom_range(0, 1);
      repeat (len) begin
        @(negedge clk_i);
        out_stall_i <= level;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drives one tick and returns at the falling edge after acceptance, valid
  // still high so back-to-back ticks need no toggle.
  task automatic send_tick(logic [1:0] axis, int meas, int targ,
                           int stick, int center, int knob);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    axis_i            <= axis;
    measured_angle_i  <= 16'(meas);
    target_angle_i    <= 16'(targ);
    stick_pulse_i     <= 12'(stick);
    stick_center_i    <= 12'(center);
    gain_knob_pulse_i <= 12'(knob);
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Registers are written only with nothing in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [CfgW-1:0] rand_slots(int kind);
    logic [CfgW-1:0] v;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: v[16*k +: 16] = 16'h0000;
        1: v[16*k +: 16] = 16'hFFFF;
        2: v[16*k +: 16] = 16'($urandom_range(1, 300));
        default: v[16*k +: 16] = kind ? 16'($urandom_range(0, 32767))
                                      : 16'($urandom_range(0, 65535));
      endcase
    end
    return v;
  endfunction

  task automatic random_setup();
    write_reg(CFG_P_LIMITS, rand_slots(0));
    write_reg(CFG_I_LIMITS, rand_slots(0));
    write_reg(CFG_D_LIMITS, rand_slots(0));
    write_reg(CFG_KP_GAINS, rand_slots(1));
    write_reg(CFG_KI_GAINS, rand_slots(1));
    write_reg(CFG_KD_GAINS, rand_slots(1));
    write_reg(CFG_REVERSE_BITS, 48'($urandom_range(0, 63)));
    case ($urandom_range(0, 3))
      0: write_reg(CFG_MANUAL_BLEND, 48'd0);
      1: write_reg(CFG_MANUAL_BLEND, 48'd65535);
      default: write_reg(CFG_MANUAL_BLEND, 48'($urandom_range(0, 65535)));
    endcase
  endtask

  // One random tick: mostly flight-like values, sometimes the full field range.
  task automatic random_tick();
    int targ, meas, center;
    targ = $urandom_range(0, 51472) - 25736;
    if ($urandom_range(0, 3) == 0) meas = $urandom_range(0, 51472) - 25736;
    else meas = targ + $urandom_range(0, 800) - 400;
    if (meas > 25736) meas = 25736;
    if (meas < -25736) meas = -25736;
    center = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(1400, 1600);
    send_tick(2'($urandom_range(0, 3)), meas, targ,
              $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(1000, 2000),
              center,
              $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(950, 2100));
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    axis_i            = '0;
    measured_angle_i  = '0;
    target_angle_i    = '0;
    stick_pulse_i     = '0;
    stick_center_i    = '0;
    gain_knob_pulse_i = '0;
    quiet             = 1'b0;
    idle_cycles       = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset config: every limit zero, so terms normalize to their sign.
    send_tick(2'd0, 25736, -25736, 1500, 1500, 1500);
    send_tick(2'd1, -25736, 25736, 4095, 0, 4095);
    send_tick(2'd3, 100, -100, 0, 4095, 0);
    settle();

    // Extremes: full limits and gains, everything reversed, no manual share.
    write_reg(CFG_P_LIMITS, '1);
    write_reg(CFG_I_LIMITS, '1);
    write_reg(CFG_D_LIMITS, '1);
    write_reg(CFG_KP_GAINS, '1);
    write_reg(CFG_KI_GAINS, '1);
    write_reg(CFG_KD_GAINS, '1);
    write_reg(CFG_REVERSE_BITS, 48'h3F);
    write_reg(CFG_MANUAL_BLEND, '0);
    write_reg(CfgIdxUnused, '1);  // must be ignored
    send_tick(2'd0, 25736, -25736, 2000, 1500, 2040);  // wrap past pi
    send_tick(2'd0, -25736, 25736, 1000, 1500, 2041);
    send_tick(2'd0, 25736, -25736, 1500, 1500, 999);   // knob below range
    send_tick(2'd1, 0, 0, 1500, 1500, 1000);
    send_tick(2'd2, 12000, -12000, 1500, 1500, 4095);
    send_tick(2'd2, -12000, 12000, 1500, 1500, 4095);  // integrator sign flip
    send_tick(2'd3, 300, 0, 1500, 1500, 1500);         // axis folds onto yaw
    settle();

    // Full manual share with tiny limits so the integrator clamps.
    write_reg(CFG_P_LIMITS, 48'h0001_0010_0100);
    write_reg(CFG_I_LIMITS, 48'h0001_0020_0200);
    write_reg(CFG_D_LIMITS, 48'h0000_0001_0003);
    write_reg(CFG_REVERSE_BITS, 48'h00);
    write_reg(CFG_MANUAL_BLEND, 48'hFFFF);
    for (int k = 0; k < 4; k++) send_tick(2'd0, 400, 0, 2000, 1500, 2040);
    send_tick(2'd1, 1000, 0, 4095, 0, 1500);
    send_tick(2'd1, -1000, 0, 0, 4095, 1500);
    send_tick(2'd2, -25736, 25736, 0, 0, 0);
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      random_setup();
      if (ph == Phases - 1) quiet = 1'b1;
      for (int k = 0; k < RandTicks / Phases; k++) random_tick();
      settle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cpa_pkg.sv
src/cpa_div.sv
src/cpa_mul.sv
src/clamped_pid_attitude_axis_top.sv
tb/testbench.sv
